/* hw/rtl/vbc_pkg.sv */
// ---------------------------------------------------------------------------
// vbc_pkg
// Shared types and constants for the volume bar classifier.
// ---------------------------------------------------------------------------
package vbc_pkg;

    // one completed price bar
    typedef struct packed {
        logic [31:0] open_price;
        logic [31:0] high_price;
        logic [31:0] low_price;
        logic [31:0] close_price;
        logic [31:0] total_volume;
        logic [31:0] bid_volume;
        logic [31:0] ask_volume;
    } t_bar_in;

    // classification result
    typedef struct packed {
        logic       climax_up;
        logic       climax_down;
        logic       high_churn;
        logic       churn_and_climax;
        logic       low_volume;
        logic [2:0] paint_code;
    } t_bar_out;

    // paint codes
    typedef enum logic [2:0] {
        PAINT_NONE     = 3'd0,
        PAINT_UP       = 3'd1,
        PAINT_DOWN     = 3'd2,
        PAINT_CHURN    = 3'd3,
        PAINT_CHURN_CL = 3'd4,
        PAINT_LOW_VOL  = 3'd5
    } t_paint;

    // register indexes
    localparam logic [1:0] REG_LOOKBACK = 2'd0;
    localparam logic [1:0] REG_BID_ASK  = 2'd1;
    localparam logic [1:0] REG_ENABLES  = 2'd2;

    localparam logic [10:0] LOOKBACK_RESET = 11'd20;
    localparam logic [4:0]  ENABLES_RESET  = 5'd31;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_WRITE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

/* hw/rtl/volume_bar_classifier.sv */
// ---------------------------------------------------------------------------
// volume_bar_classifier
// Classifies price bars as climax, churn or low volume against rolling
// windows of recent bars, using one shared multiplier, a bit-serial divider
// and a single-port scan of the window memories.
// ---------------------------------------------------------------------------
// sequence: three products in S_MUL, the ratio divide in S_DIV, the window write
//   in S_WRITE, the window scan in S_SCAN and the result load in S_DONE;
//   a bar with zero range skips the divide steps
// throughput: one bar at a time; the next request is taken the cycle after the
//   result register is loaded, which waits while the result channel is stalled
// reset: config registers go to lookback 20, bid/ask mode on, all enables;
//   window contents are undefined, write position and bar count clear
module volume_bar_classifier #(
    parameter int WINDOW_MAX          = 1024,
    parameter int RATIO_FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // bar request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  vbc_pkg::t_bar_in   i_bar,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output vbc_pkg::t_bar_out  o_bar,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW  = $clog2(WINDOW_MAX);
    localparam int CW  = $clog2(WINDOW_MAX + 1);
    localparam int SW  = (CW > 11) ? CW : 11;
    localparam int RW  = 32 + RATIO_FRACTION_BITS;
    localparam int DCW = $clog2(RW + 1);

    // window memories
    logic [63:0]   mem_prod [WINDOW_MAX];
    logic [63:0]   mem_bprod[WINDOW_MAX];
    logic [63:0]   mem_aprod[WINDOW_MAX];
    logic [RW-1:0] mem_ratio[WINDOW_MAX];
    logic [31:0]   mem_vol  [WINDOW_MAX];

    vbc_pkg::t_state r_state, n_state;

    logic [10:0] r_lookback;
    logic        r_bid_ask;
    logic [4:0]  r_enables;

    logic [31:0] r_open, r_close, r_vol, r_bidv, r_askv, r_range;
    logic [63:0] r_prod, r_bprod, r_aprod;
    logic [1:0]  r_mcnt;
    logic [32:0] r_rem;
    logic [RW-1:0] r_quo;
    logic [DCW-1:0] r_dcnt;
    logic [AW-1:0] r_wr_pos;
    logic [CW-1:0] r_bars_seen;
    logic [SW-1:0] r_span, r_k;
    logic          r_rd_valid;
    logic [63:0]   r_rd_prod, r_rd_bprod, r_rd_aprod;
    logic [RW-1:0] r_rd_ratio;
    logic [31:0]   r_rd_vol;
    logic r_max_p, r_max_b, r_max_a, r_max_r, r_min_v;
    logic r_out_valid;
    vbc_pkg::t_bar_out r_out;

    logic in_acc, out_acc, cfg_wr, out_load;
    logic [31:0]   mul_a;
    logic [63:0]   mul_p;
    logic [32:0]   div_sh;
    logic          div_ge;
    logic [CW-1:0] bars_next;
    logic [SW-1:0] span_calc;
    logic [AW:0]   rd_off;
    logic [AW:0]   rd_wide;
    logic [AW-1:0] rd_addr;
    logic          scan_issue;
    logic f_up, f_dn, f_ch, f_cc, f_lv;
    vbc_pkg::t_bar_out res;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_acc  = r_out_valid && i_out_ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign o_in_ready  = (r_state == vbc_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_bar       = r_out;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookback <= vbc_pkg::LOOKBACK_RESET;
            r_bid_ask  <= 1'b1;
            r_enables  <= vbc_pkg::ENABLES_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                vbc_pkg::REG_LOOKBACK: r_lookback <= pwdata[10:0];
                vbc_pkg::REG_BID_ASK:  r_bid_ask  <= pwdata[0];
                vbc_pkg::REG_ENABLES:  r_enables  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            vbc_pkg::REG_LOOKBACK: prdata = {21'd0, r_lookback};
            vbc_pkg::REG_BID_ASK:  prdata = {31'd0, r_bid_ask};
            vbc_pkg::REG_ENABLES:  prdata = {27'd0, r_enables};
            default:               prdata = 32'd0;
        endcase
    end

    // shared multiplier, one product per cycle
    always_comb begin
        case (r_mcnt)
            2'd0:    mul_a = r_vol;
            2'd1:    mul_a = r_bidv;
            default: mul_a = r_askv;
        endcase
        mul_p = 64'(mul_a) * 64'(r_range);
    end

    // restoring divider step
    assign div_sh = {r_rem[31:0], r_quo[RW-1]};
    assign div_ge = (div_sh >= {1'b0, r_range});

    // window span for this bar
    always_comb begin
        bars_next = (r_bars_seen < CW'(WINDOW_MAX)) ? r_bars_seen + 1'b1 : r_bars_seen;
        span_calc = SW'(r_lookback);
        if (span_calc == '0) span_calc = SW'(1);
        if (span_calc > SW'(WINDOW_MAX)) span_calc = SW'(WINDOW_MAX);
        if (span_calc > SW'(bars_next)) span_calc = SW'(bars_next);
    end

    // read address walks back from the current entry with wrap;
    // the write position has already moved one past the current entry
    always_comb begin
        rd_off = r_k[AW:0] + (AW+1)'(1);
        if ({1'b0, r_wr_pos} >= rd_off) begin
            rd_wide = {1'b0, r_wr_pos} - rd_off;
        end else begin
            rd_wide = {1'b0, r_wr_pos} + (AW+1)'(WINDOW_MAX) - rd_off;
        end
        rd_addr    = rd_wide[AW-1:0];
        scan_issue = (r_state == vbc_pkg::S_SCAN) && (r_k < r_span);
    end

    // window memories, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (r_state == vbc_pkg::S_WRITE) begin
            mem_prod[r_wr_pos]  <= r_prod;
            mem_bprod[r_wr_pos] <= r_bprod;
            mem_aprod[r_wr_pos] <= r_aprod;
            mem_ratio[r_wr_pos] <= r_quo;
            mem_vol[r_wr_pos]   <= r_vol;
        end
        if (scan_issue) begin
            r_rd_prod  <= mem_prod[rd_addr];
            r_rd_bprod <= mem_bprod[rd_addr];
            r_rd_aprod <= mem_aprod[rd_addr];
            r_rd_ratio <= mem_ratio[rd_addr];
            r_rd_vol   <= mem_vol[rd_addr];
        end
    end

    // result flags and paint code
    always_comb begin
        f_up = r_max_a && (r_open < r_close) && r_enables[0];
        f_dn = r_max_b && (r_open > r_close) && r_enables[1];
        f_ch = r_max_r && r_enables[2];
        f_cc = r_max_p && r_max_r && r_enables[3];
        f_lv = r_min_v && r_enables[4];
        res.climax_up        = f_up;
        res.climax_down      = f_dn;
        res.high_churn       = f_ch;
        res.churn_and_climax = f_cc;
        res.low_volume       = f_lv;
        res.paint_code       = vbc_pkg::PAINT_NONE;
        if (f_up) res.paint_code = vbc_pkg::PAINT_UP;
        if (f_dn) res.paint_code = vbc_pkg::PAINT_DOWN;
        if (f_ch) res.paint_code = vbc_pkg::PAINT_CHURN;
        if (f_cc) res.paint_code = vbc_pkg::PAINT_CHURN_CL;
        if (f_lv) res.paint_code = vbc_pkg::PAINT_LOW_VOL;
    end

    assign out_load = (r_state == vbc_pkg::S_DONE) && (!r_out_valid || i_out_ready);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vbc_pkg::S_IDLE:  if (in_acc) n_state = vbc_pkg::S_MUL;
            vbc_pkg::S_MUL:   if (r_mcnt == 2'd2) n_state = vbc_pkg::S_DIV;
            vbc_pkg::S_DIV:   if (r_dcnt == '0) n_state = vbc_pkg::S_WRITE;
            vbc_pkg::S_WRITE: n_state = vbc_pkg::S_SCAN;
            vbc_pkg::S_SCAN:  if (!scan_issue && !r_rd_valid) n_state = vbc_pkg::S_DONE;
            vbc_pkg::S_DONE:  if (out_load) n_state = vbc_pkg::S_IDLE;
            default:          n_state = vbc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= vbc_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // control counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos    <= '0;
            r_bars_seen <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= scan_issue;
            if (r_state == vbc_pkg::S_WRITE) begin
                r_bars_seen <= bars_next;
                r_wr_pos    <= (r_wr_pos == AW'(WINDOW_MAX - 1)) ? '0 : r_wr_pos + 1'b1;
            end
            if (out_load)     r_out_valid <= 1'b1;
            else if (out_acc) r_out_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (out_load) r_out <= res;
        case (r_state)
            vbc_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_open  <= i_bar.open_price;
                    r_close <= i_bar.close_price;
                    r_vol   <= i_bar.total_volume;
                    r_bidv  <= r_bid_ask ? i_bar.bid_volume : i_bar.total_volume;
                    r_askv  <= r_bid_ask ? i_bar.ask_volume : i_bar.total_volume;
                    r_range <= (i_bar.high_price >= i_bar.low_price) ?
                               i_bar.high_price - i_bar.low_price : 32'd0;
                    r_mcnt  <= 2'd0;
                end
            end
            vbc_pkg::S_MUL: begin
                case (r_mcnt)
                    2'd0:    r_prod  <= mul_p;
                    2'd1:    r_bprod <= mul_p;
                    default: r_aprod <= mul_p;
                endcase
                r_mcnt <= r_mcnt + 2'd1;
                // divider setup
                r_rem  <= '0;
                r_quo  <= (r_range == 32'd0) ? '0 : (RW'(r_vol) << RATIO_FRACTION_BITS);
                r_dcnt <= (r_range == 32'd0) ? '0 : DCW'(RW);
            end
            vbc_pkg::S_DIV: begin
                if (r_dcnt != '0) begin
                    r_rem  <= div_ge ? div_sh - {1'b0, r_range} : div_sh;
                    r_quo  <= {r_quo[RW-2:0], div_ge};
                    r_dcnt <= r_dcnt - 1'b1;
                end
            end
            vbc_pkg::S_WRITE: begin
                r_span  <= span_calc;
                r_k     <= SW'(1);
                r_max_p <= 1'b1;
                r_max_b <= 1'b1;
                r_max_a <= 1'b1;
                r_max_r <= 1'b1;
                r_min_v <= 1'b1;
            end
            vbc_pkg::S_SCAN: begin
                if (scan_issue) r_k <= r_k + 1'b1;
                if (r_rd_valid) begin
                    if (r_rd_prod  > r_prod)  r_max_p <= 1'b0;
                    if (r_rd_bprod > r_bprod) r_max_b <= 1'b0;
                    if (r_rd_aprod > r_aprod) r_max_a <= 1'b0;
                    if (r_rd_ratio > r_quo)   r_max_r <= 1'b0;
                    if (r_rd_vol   < r_vol)   r_min_v <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    // checks
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vbc_pkg::S_SCAN) |-> (r_k <= r_span))
        else $error("scan index past window span");
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == vbc_pkg::S_MUL))
        else $error("accepted bar did not start multiply");
    a_bars_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bars_seen <= CW'(WINDOW_MAX))
        else $error("bar count above window size");
    a_span_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vbc_pkg::S_SCAN) |-> (r_span <= SW'(r_bars_seen)) && (r_span != '0))
        else $error("span exceeds stored bars");
    a_load_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_state == vbc_pkg::S_IDLE) && r_out_valid)
        else $error("result load did not return to idle");

endmodule
